// ===== design/acr_pkg.sv =====
// Package for the ARP cache resolver: payload structs, cache entry layout,
// outcome codes, opcode and register constants.
// No dependencies.
package acr_pkg;

    typedef struct packed {
        logic        action;
        logic [31:0] query_ip;
        logic [47:0] src_mac;
        logic [31:0] tgt_ip;
        logic [15:0] opcode;
        logic [15:0] frame_length;
    } t_item;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [31:0] ip_out;
        logic [47:0] mac_out;
    } t_result;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
    } t_entry;

    typedef enum logic [2:0] {
        OUT_HIT        = 3'd0,
        OUT_MISS       = 3'd1,
        OUT_SEND_REPLY = 3'd2,
        OUT_NOT_FOR_US = 3'd3,
        OUT_LEARNED    = 3'd4,
        OUT_FULL       = 3'd5,
        OUT_TOO_SHORT  = 3'd6,
        OUT_OTHER_OP   = 3'd7
    } t_outcome;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    localparam logic        ACT_LOOKUP    = 1'b0;
    localparam logic        ACT_FRAME     = 1'b1;
    localparam logic [15:0] OP_REQUEST    = 16'd1;
    localparam logic [15:0] OP_REPLY      = 16'd2;
    localparam logic [15:0] MIN_FRAME_LEN = 16'd42;
    localparam logic        CFG_OWN_IP    = 1'b0;

endpackage

// ===== design/arp_cache_resolver.sv =====
// ARP cache resolver top level: IPv4-to-MAC cache in a synchronous memory
// with a scanning sequencer. Depends on acr_pkg.
//
// Usage: an item is transferred on i_item when start is high and busy is low.
// Each item gives exactly one result on o_result, marked by o_done for one
// cycle; the receiver cannot hold it off. Configuration is written on
// i_cfg_we/i_cfg_addr/i_cfg_wdata at any clock edge, with no handshake.
// Register 0 is our IPv4 address; register 1 (our MAC) is accepted but no
// result carries it, so it is not stored.
// Frames that are too short, ARP requests and unknown opcodes give their
// result through the registered o_done and o_result without a scan, and busy
// stays low. Lookups and ARP replies scan the filled entries through the
// single registered read port of the cache memory, one entry per cycle,
// comparing each entry once its read data is registered: a lookup stops at
// its first hit, and a miss or a reply runs through every filled entry. With
// an empty cache they answer without a scan, as the frames above do. The
// read port sets this rate; busy is high during the scan.
// Reset (synchronous, active low) empties the cache by clearing the fill
// count and clears our IP address. Entries fill in order and are never
// evicted, so the fill count alone marks which entries are valid.
module arp_cache_resolver #(
    parameter int CACHE_ENTRIES = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  acr_pkg::t_item  i_item,
    output logic            o_done,
    output acr_pkg::t_result o_result,
    input  logic            i_cfg_we,
    input  logic            i_cfg_addr,
    input  logic [47:0]     i_cfg_wdata
);
    import acr_pkg::*;

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CACHE_ENTRIES);

    t_entry            r_mem [CACHE_ENTRIES];
    t_entry            r_rd_data;

    t_state            r_state, n_state;
    t_item             r_item, n_item;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_cmp_vld, n_cmp_vld;
    logic [IDX_W-1:0]  r_cmp_idx, n_cmp_idx;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic              r_found, n_found;
    logic              r_done, n_done;
    t_result           r_result, n_result;
    logic [31:0]       r_own_ip;

    logic              rd_en;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_entry            wr_data;
    logic              hit;
    logic              last;

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    assign hit  = r_cmp_vld && (r_rd_data.ip == r_item.query_ip);
    assign last = r_cmp_vld && ((CNT_W'(r_cmp_idx) + CNT_W'(1)) == r_fill);

    // Cache memory: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip <= '0;
        end else if (i_cfg_we && (i_cfg_addr == CFG_OWN_IP)) begin
            r_own_ip <= i_cfg_wdata[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_done    <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_done    <= n_done;
            r_cmp_vld <= n_cmp_vld;
        end
        r_item    <= n_item;
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_found   <= n_found;
        r_result  <= n_result;
    end

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_idx     = r_idx;
        n_cmp_vld = 1'b0;
        n_cmp_idx = r_cmp_idx;
        n_fill    = r_fill;
        n_found   = r_found;
        n_done    = 1'b0;
        n_result  = r_result;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = r_fill[IDX_W-1:0];
        wr_data   = '{ip: r_item.query_ip, mac: r_item.src_mac};

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_item  = i_item;
                    n_idx   = '0;
                    n_found = 1'b0;
                    if (i_item.action == ACT_LOOKUP) begin
                        if (r_fill == '0) begin
                            n_done   = 1'b1;
                            n_result = '{outcome: OUT_MISS, ip_out: i_item.query_ip,
                                         mac_out: '0};
                        end else begin
                            n_state = ST_SCAN;
                        end
                    end else if (i_item.frame_length < MIN_FRAME_LEN) begin
                        n_done   = 1'b1;
                        n_result = '{outcome: OUT_TOO_SHORT, ip_out: '0, mac_out: '0};
                    end else if (i_item.opcode == OP_REQUEST) begin
                        n_done = 1'b1;
                        if (i_item.tgt_ip == r_own_ip) begin
                            n_result = '{outcome: OUT_SEND_REPLY, ip_out: i_item.query_ip,
                                         mac_out: i_item.src_mac};
                        end else begin
                            n_result = '{outcome: OUT_NOT_FOR_US, ip_out: '0, mac_out: '0};
                        end
                    end else if (i_item.opcode == OP_REPLY) begin
                        if (r_fill == '0) begin
                            // Empty cache: the pair goes straight into the first slot.
                            wr_en    = 1'b1;
                            wr_addr  = '0;
                            wr_data  = '{ip: i_item.query_ip, mac: i_item.src_mac};
                            n_fill   = CNT_W'(1);
                            n_done   = 1'b1;
                            n_result = '{outcome: OUT_LEARNED, ip_out: i_item.query_ip,
                                         mac_out: i_item.src_mac};
                        end else begin
                            n_state = ST_SCAN;
                        end
                    end else begin
                        n_done   = 1'b1;
                        n_result = '{outcome: OUT_OTHER_OP, ip_out: '0, mac_out: '0};
                    end
                end
            end

            ST_SCAN: begin
                // Read side: issue the next filled entry while the compare works on the entry read before it.
                if (r_idx < r_fill) begin
                    rd_en     = 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx[IDX_W-1:0];
                    n_idx     = r_idx + CNT_W'(1);
                end

                if (r_item.action == ACT_LOOKUP) begin
                    if (hit) begin
                        n_state   = ST_IDLE;
                        n_cmp_vld = 1'b0;
                        n_done    = 1'b1;
                        n_result  = '{outcome: OUT_HIT, ip_out: '0, mac_out: r_rd_data.mac};
                    end else if (last) begin
                        n_state  = ST_IDLE;
                        n_done   = 1'b1;
                        n_result = '{outcome: OUT_MISS, ip_out: r_item.query_ip, mac_out: '0};
                    end
                end else begin
                    // Every matching entry takes the new MAC, written behind the reads.
                    if (hit) begin
                        wr_en   = 1'b1;
                        wr_addr = r_cmp_idx;
                        n_found = 1'b1;
                    end
                    if (last) begin
                        n_state  = ST_IDLE;
                        n_done   = 1'b1;
                        n_result = '{outcome: OUT_LEARNED, ip_out: r_item.query_ip,
                                     mac_out: r_item.src_mac};
                        if (!r_found && !hit) begin
                            if (r_fill < FULL_COUNT) begin
                                wr_en   = 1'b1;
                                wr_addr = r_fill[IDX_W-1:0];
                                n_fill  = r_fill + CNT_W'(1);
                            end else begin
                                n_result.outcome = OUT_FULL;
                            end
                        end
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/acr_checker.sv =====
// Port-level checker for the ARP cache resolver, with its bind to the top level.
// Depends on acr_pkg and arp_cache_resolver.
module acr_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input acr_pkg::t_item   i_item,
    input logic             o_done,
    input acr_pkg::t_result o_result
);
    import acr_pkg::*;

    // A result always closes the work on its item.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // Every transfer either starts a scan or answers in the next cycle.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("transfer neither started a scan nor answered");

    a_short_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.action == ACT_FRAME
         && i_item.frame_length < MIN_FRAME_LEN)
        |=> (o_done && o_result.outcome == OUT_TOO_SHORT))
        else $error("short frame not reported as too short");

    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.outcome == OUT_TOO_SHORT
                    || o_result.outcome == OUT_NOT_FOR_US
                    || o_result.outcome == OUT_OTHER_OP))
        |-> (o_result.ip_out == '0 && o_result.mac_out == '0))
        else $error("dropped frame result carries an address");

    a_hit_no_ip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.outcome == OUT_HIT) |-> (o_result.ip_out == '0))
        else $error("hit result carries an IP");

endmodule

bind arp_cache_resolver acr_checker u_acr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_done   (o_done),
    .o_result (o_result)
);
